### design/kdm_pkg.sv
// Shared types and constants for the key to dense id mapper.
package kdm_pkg;

    // Fixed widths of the transaction fields.
    localparam int IN_KEY_W = 32;
    localparam int IDENT_W  = 8;

    // Codes of the kind field.
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic                kind;
        logic [IN_KEY_W-1:0] key;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic               was_present;
        logic               table_full;
    } t_out;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic valid;
        logic hit;
        logic ins;
    } t_tok;

endpackage

### design/key_to_dense_id_mapper.sv
// Top level of the key to dense id mapper: a row of compare cells and control.
//
// Usage: a transaction is accepted at a rising edge with start high and busy
// low. A lookup compares the key with every live entry; a hit returns the
// entry's id, a miss appends the key at the entry count and returns that id,
// and a miss on a full table returns table_full. A clear empties the table.
// Each transaction gives one result, shown for one cycle with o_strobe high.
// A lookup passes a search token through the row of TABLE_DEPTH cells,
// one cell per cycle; the result register follows the last cell, and busy
// is high until the cycle of the strobe. The block takes no new transaction
// while a lookup is in the row, so the length of the cell row sets the
// lookup rate. A clear takes effect at once, its result shows in the next
// cycle and busy stays low.
// Reset empties the table (entry count zero) and clears the token row; no
// clearing pass is needed. The receiver cannot stall: every result must be
// taken in the cycle it is shown.
module key_to_dense_id_mapper import kdm_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                 r_busy;
    logic                 r_inj;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]     r_count;
    logic                 r_strobe;
    t_out                 r_result;
    logic                 n_busy;
    logic                 n_inj;
    logic [CNT_W-1:0]     n_count;
    logic                 n_strobe;
    t_out                 n_result;
    logic                 w_accept;
    logic                 w_done;
    t_tok                 w_last;
    logic [IDX_W-1:0]     w_last_id;
    t_tok                 w_tok [0:TABLE_DEPTH];
    logic [IDX_W-1:0]     w_id  [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_tok_valid;

    assign w_accept  = start & ~r_busy;
    assign w_last    = w_tok[TABLE_DEPTH];
    assign w_last_id = w_id[TABLE_DEPTH];
    assign w_done    = w_last.valid;

    // Token entering the first cell, registered together with the captured key.
    assign w_tok[0] = '{valid: r_inj, hit: 1'b0, ins: 1'b0};
    assign w_id[0]  = '0;

    // Row of table cells, each handing the token to its neighbor.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        kdm_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .INDEX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_id    (w_id[g]),
            .i_key   (r_key),
            .i_count (r_count),
            .o_tok   (w_tok[g+1]),
            .o_id    (w_id[g+1])
        );
        assign w_tok_valid[g] = w_tok[g+1].valid;
    end

    // Control: accept, token launch, entry count and result strobe.
    always_comb begin
        n_busy   = r_busy;
        n_inj    = 1'b0;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_result = r_result;
        if (w_accept) begin
            if (i_item.kind == KIND_CLEAR) begin
                n_count  = '0;
                n_strobe = 1'b1;
                n_result = '0;
            end else begin
                n_busy = 1'b1;
                n_inj  = 1'b1;
            end
        end
        if (w_done) begin
            n_busy               = 1'b0;
            n_strobe             = 1'b1;
            n_result.ident       = (w_last.hit | w_last.ins) ? IDENT_W'(w_last_id)
                                                             : '0;
            n_result.was_present = w_last.hit;
            n_result.table_full  = ~w_last.hit & ~w_last.ins;
            if (w_last.ins) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_inj    <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_inj    <= n_inj;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers: captured key and result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= KEY_WIDTH'(i_item.key);
        end
        r_result <= n_result;
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // At most one search token is ever in the cell row.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one search token in the cell row");

    // The entry count never exceeds the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A full result is only given when the table is full.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.table_full) |-> (r_count == CNT_W'(TABLE_DEPTH)))
        else $error("table_full reported on a table with free entries");

    // A token leaving the row ends the busy period and strobes a result.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (o_strobe && !busy))
        else $error("finished lookup did not produce a result");
`endif

endmodule

### design/kdm_cell.sv
// One table entry of the mapper: stored key, compare and token stage.
module kdm_cell import kdm_pkg::*; #(
    parameter int KEY_WIDTH = 32,
    parameter int IDX_W     = 8,
    parameter int CNT_W     = 9,
    parameter int INDEX     = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tok                 i_tok,
    input  logic [IDX_W-1:0]     i_id,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]     i_count,
    output t_tok                 o_tok,
    output logic [IDX_W-1:0]     o_id
);

    logic [KEY_WIDTH-1:0] r_stored;
    t_tok                 r_tok;
    logic [IDX_W-1:0]     r_id;
    t_tok                 n_tok;
    logic [IDX_W-1:0]     n_id;
    logic                 w_live;
    logic                 w_below;
    logic                 w_at;
    logic                 w_hit;
    logic                 w_ins;

    // A token that has not yet been resolved is still searching.
    assign w_live  = i_tok.valid & ~i_tok.hit & ~i_tok.ins;
    assign w_below = CNT_W'(INDEX) < i_count;
    assign w_at    = CNT_W'(INDEX) == i_count;
    assign w_hit   = w_live & w_below & (r_stored == i_key);
    assign w_ins   = w_live & w_at;

    // Resolve the token here on a hit or at the first free entry.
    always_comb begin
        n_tok       = i_tok;
        n_tok.hit   = i_tok.hit | w_hit;
        n_tok.ins   = i_tok.ins | w_ins;
        n_id        = (w_hit | w_ins) ? IDX_W'(INDEX) : i_id;
    end

    // Token stage, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Payload: id travelling with the token and the stored key.
    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        if (w_ins) begin
            r_stored <= i_key;
        end
    end

    assign o_tok = r_tok;
    assign o_id  = r_id;

endmodule

### verif/key_to_dense_id_mapper_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the key to dense id mapper with a table predictor and scoreboard.
module key_to_dense_id_mapper_tb;
    import kdm_pkg::*;

    localparam int DEPTH       = 256;
    localparam int KEY_W       = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_GAP     = 60;

    // Scoreboard: mirrors the id table and holds the results still owed by the block.
    class id_map_scoreboard;
        logic [KEY_W-1:0] key_store [DEPTH];
        int unsigned      live_count;
        t_out             pending_ids [$];
        int unsigned      errors;

        function new();
            live_count = 0;
            errors     = 0;
        endfunction

        // Work out the result of an accepted transaction and queue it.
        function void note_item(t_in item);
            t_out             exp_res;
            logic [KEY_W-1:0] k;
            bit               found;
            exp_res = '0;
            k       = item.key[KEY_W-1:0];
            found   = 1'b0;
            if (item.kind == KIND_CLEAR) begin
                live_count = 0;
            end else begin
                // Only entries below the live count take part in the compare.
                for (int i = 0; i < live_count; i++) begin
                    if (!found && key_store[i] == k) begin
                        found               = 1'b1;
                        exp_res.ident       = IDENT_W'(i);
                        exp_res.was_present = 1'b1;
                    end
                end
                if (!found) begin
                    if (live_count >= DEPTH) begin
                        exp_res.table_full = 1'b1;
                    end else begin
                        key_store[live_count] = k;
                        exp_res.ident         = IDENT_W'(live_count);
                        live_count++;
                    end
                end
            end
            pending_ids = {pending_ids, exp_res};
        endfunction

        // Compare one result with the oldest expectation, field by field.
        function void check_result(t_out got);
            t_out exp_res;
            if (pending_ids.size() == 0) begin
                $error("result with no transaction outstanding: ident %0d", got.ident);
                errors++;
                return;
            end
            exp_res = pending_ids.pop_front();
            if (got.ident !== exp_res.ident) begin
                $error("ident: expected %0d, got %0d", exp_res.ident, got.ident);
                errors++;
            end
            if (got.was_present !== exp_res.was_present) begin
                $error("was_present: expected %0b, got %0b", exp_res.was_present,
                       got.was_present);
                errors++;
            end
            if (got.table_full !== exp_res.table_full) begin
                $error("table_full: expected %0b, got %0b", exp_res.table_full,
                       got.table_full);
                errors++;
            end
        endfunction

        function int count_pending();
            return pending_ids.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  in_item = '0;
    logic busy;
    logic o_strobe;
    t_out o_result;

    id_map_scoreboard sb;
    int               idle_pct = 0;
    int               quiet_cycles = 0;
    logic [KEY_W-1:0] seen_keys [$];

    key_to_dense_id_mapper #(
        .TABLE_DEPTH (DEPTH),
        .KEY_WIDTH   (KEY_W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (in_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Sample both sides at the rising edge; results are checked before new predictions.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_result);
            end
            if (start && !busy) begin
                sb.note_item(in_item);
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one transaction and hold it until the block takes it.
    task automatic send(input logic kind, input logic [IN_KEY_W-1:0] key);
        in_item <= '{kind: kind, key: key};
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Random sender gap, bounded so the watchdog limit stays meaningful.
    task automatic sender_gap();
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < idle_pct) begin
            n++;
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic lookup(input logic [IN_KEY_W-1:0] key);
        sender_gap();
        send(KIND_LOOKUP, key);
        seen_keys = {seen_keys, key};
    endtask

    task automatic clear_table(input logic [IN_KEY_W-1:0] key);
        sender_gap();
        send(KIND_CLEAR, key);
        seen_keys.delete();
    endtask

    // Half the picks are keys seen since the last clear, with corner values and fresh random keys.
    function automatic logic [IN_KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5 && seen_keys.size() > 0) begin
            return seen_keys[$urandom_range(seen_keys.size() - 1)];
        end else if (sel == 5) begin
            return $urandom_range(15);
        end else if (sel == 6) begin
            return 32'hFFFF_FFFF - $urandom_range(15);
        end
        return $urandom;
    endfunction

    task automatic random_segment(input int count, input int pct);
        idle_pct = pct;
        repeat (count) begin
            if ($urandom_range(99) < 4) begin
                clear_table($urandom);
            end else begin
                lookup(pick_key());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, extreme keys, hits, stale entries after a clear.
        clear_table(32'h0000_0000);
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
        lookup(32'h5555_5555);
        lookup(32'hAAAA_AAAA);
        lookup(32'h8000_0000);
        lookup(32'h0000_0001);
        lookup(32'hAAAA_AAAA);
        // A clear carries a key that must be ignored.
        clear_table(32'hFFFF_FFFF);
        // Old entries are still in the store but must not hit after the clear.
        lookup(32'hFFFF_FFFF);
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
        clear_table(32'h1234_5678);
        clear_table(32'h0000_0000);
        lookup(32'h1234_5678);
        clear_table(32'h8765_4321);

        // Random segments across the idling phases; the receiver cannot stall.
        random_segment(32, 0);
        random_segment(32, 85);
        random_segment(32, 0);
        random_segment(32, 12);

        // Hold the sender until every outstanding result has come back.
        start <= 1'b0;
        while (sb.count_pending() != 0) @(posedge i_clk);

        // Fill the table completely with distinct keys, with hits mixed in.
        idle_pct = 0;
        clear_table($urandom);
        for (int i = 0; i < DEPTH; i++) begin
            lookup(($urandom & 32'hFFFF_FF00) | i);
            if ($urandom_range(99) < 10) begin
                lookup(seen_keys[$urandom_range(seen_keys.size() - 1)]);
            end
        end

        // Full table: misses are refused, hits still work up to the top id.
        idle_pct = 12;
        lookup(32'hFFFF_FFFF);
        lookup(32'h0000_0000);
        repeat (22) begin
            if ($urandom_range(1) == 0) begin
                lookup($urandom);
            end else begin
                lookup(seen_keys[$urandom_range(seen_keys.size() - 1)]);
            end
        end
        clear_table($urandom);
        random_segment(8, 0);

        // Drain, then give the block time to show any stray result.
        start <= 1'b0;
        while (sb.count_pending() != 0) @(posedge i_clk);
        repeat (DEPTH + 10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
